// ===== sv/rv64ie_pkg.sv =====
// Package for the RV64IM integer execute unit: opcodes, item types and the
// front-to-back command struct. No dependencies.
`default_nettype none
package rv64ie_pkg;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1B;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3B;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    typedef enum logic [2:0] {
        K_ALU    = 3'd0,
        K_MUL    = 3'd1,
        K_DIV    = 3'd2,
        K_FENCE  = 3'd3,
        K_ILLEGAL = 3'd4
    } t_kind;

    typedef struct packed {
        logic [6:0]  op;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [4:0]  shift_field;
        logic [4:0]  dest_index;
        logic [31:0] instruction_word;
        logic [63:0] src1_value;
        logic [63:0] src2_value;
        logic signed [63:0] immediate;
        logic [63:0] insn_address;
    } t_in_item;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  write_index;
        logic [63:0] write_value;
        logic        illegal;
        logic [31:0] trap_value;
        logic        retired;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic        word;
        logic [2:0]  funct3;
        logic        alt;
        logic        pass_b;
        logic [5:0]  shamt;
        logic [4:0]  dest_index;
        logic [31:0] instruction_word;
        logic [63:0] opa;
        logic [63:0] opb;
    } t_cmd;

endpackage
`default_nettype wire

// ===== sv/rv64im_integer_execute.sv =====
// Top level of the RV64IM integer execute unit.
// Path from acceptance to result: the queue entry, the setup stage, the 64-stage
// pipelined divider that every item passes through and the output register;
// throughput one item per cycle while the output is not stalled.
// Synchronous active-low reset empties the queue and all pipeline valid bits.
// Depends on rv64ie_pkg, rv64ie_front, rv64ie_queue and rv64ie_back.
`default_nettype none
module rv64im_integer_execute (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire rv64ie_pkg::t_in_item  i_item,
    output logic                       o_valid,
    input  wire                        i_stall,
    output rv64ie_pkg::t_out_item      o_item
);

    rv64ie_pkg::t_cmd w_cmd;
    rv64ie_pkg::t_cmd w_qcmd;
    logic             w_full;
    logic             w_qvalid;
    logic             w_bready;
    logic             w_push;
    logic             w_pop;

    assign o_stall = w_full;
    assign w_push  = i_valid && !w_full;
    assign w_pop   = w_qvalid && w_bready;

    rv64ie_front u_front (
        .i_item (i_item),
        .o_cmd  (w_cmd)
    );

    rv64ie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qcmd)
    );

    rv64ie_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_cmd   (w_qcmd),
        .o_ready (w_bready),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

endmodule
`default_nettype wire

// ===== sv/rv64ie_front.sv =====
// Front end: accepts items, classifies them and selects operands.
// Depends on rv64ie_pkg.
`default_nettype none
module rv64ie_front (
    input  wire rv64ie_pkg::t_in_item i_item,
    output rv64ie_pkg::t_cmd          o_cmd
);

    logic        w_m;
    logic        w_alt;
    logic [2:0]  w_f3;

    always_comb begin
        w_m   = (i_item.funct7 == rv64ie_pkg::F7_MULDIV);
        w_alt = i_item.funct7[5];
        w_f3  = i_item.funct3;
        o_cmd = '0;
        o_cmd.kind             = rv64ie_pkg::K_ALU;
        o_cmd.funct3           = w_f3;
        o_cmd.alt              = w_alt;
        o_cmd.dest_index       = i_item.dest_index;
        o_cmd.instruction_word = i_item.instruction_word;
        o_cmd.opa              = i_item.src1_value;
        o_cmd.opb              = i_item.src2_value;
        o_cmd.shamt            = i_item.src2_value[5:0];
        case (i_item.op)
            rv64ie_pkg::OP_LUI: begin
                o_cmd.funct3 = rv64ie_pkg::F3_ADD;
                o_cmd.alt    = 1'b0;
                o_cmd.pass_b = 1'b1;
                o_cmd.opb    = i_item.immediate;
            end
            rv64ie_pkg::OP_AUIPC: begin
                o_cmd.funct3 = rv64ie_pkg::F3_ADD;
                o_cmd.alt    = 1'b0;
                o_cmd.opa    = i_item.insn_address;
                o_cmd.opb    = i_item.immediate;
            end
            rv64ie_pkg::OP_IMM: begin
                o_cmd.opb   = i_item.immediate;
                o_cmd.shamt = {i_item.funct7[0], i_item.shift_field};
                o_cmd.alt   = w_alt && (w_f3 == rv64ie_pkg::F3_SRL);
            end
            rv64ie_pkg::OP_IMM32: begin
                o_cmd.word  = 1'b1;
                o_cmd.opb   = i_item.immediate;
                o_cmd.shamt = {1'b0, i_item.shift_field};
                o_cmd.alt   = w_alt && (w_f3 == rv64ie_pkg::F3_SRL);
                if (w_f3 != rv64ie_pkg::F3_ADD && w_f3 != rv64ie_pkg::F3_SLL &&
                        w_f3 != rv64ie_pkg::F3_SRL) begin
                    o_cmd.kind = rv64ie_pkg::K_ILLEGAL;
                end
            end
            rv64ie_pkg::OP_REG: begin
                if (w_m) begin
                    o_cmd.kind = w_f3[2] ? rv64ie_pkg::K_DIV : rv64ie_pkg::K_MUL;
                end
            end
            rv64ie_pkg::OP_REG32: begin
                o_cmd.word  = 1'b1;
                o_cmd.shamt = {1'b0, i_item.src2_value[4:0]};
                if (w_m) begin
                    if (w_f3[2]) begin
                        o_cmd.kind = rv64ie_pkg::K_DIV;
                    end else if (w_f3 == rv64ie_pkg::F3_MUL) begin
                        o_cmd.kind = rv64ie_pkg::K_MUL;
                    end else begin
                        o_cmd.kind = rv64ie_pkg::K_ILLEGAL;
                    end
                end else if (w_f3 != rv64ie_pkg::F3_ADD && w_f3 != rv64ie_pkg::F3_SLL &&
                        w_f3 != rv64ie_pkg::F3_SRL) begin
                    o_cmd.kind = rv64ie_pkg::K_ILLEGAL;
                end
            end
            rv64ie_pkg::OP_FENCE: begin
                o_cmd.kind = rv64ie_pkg::K_FENCE;
            end
            default: begin
                o_cmd.kind = rv64ie_pkg::K_ILLEGAL;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/rv64ie_queue.sv =====
// Two-entry queue between the front end and the back end.
// Depends on rv64ie_pkg.
`default_nettype none
module rv64ie_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  wire rv64ie_pkg::t_cmd    i_data,
    output logic                     o_full,
    input  wire                      i_pop,
    output logic                     o_valid,
    output rv64ie_pkg::t_cmd         o_data
);

    rv64ie_pkg::t_cmd r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

// ===== sv/rv64ie_back.sv =====
// Back end: a setup stage, 64 divide stages and an output register that compute
// ALU, multiply and divide results. The divider is a 64-step radix-2 array
// pipelined one quotient bit per stage. Depends on rv64ie_pkg.
`default_nettype none
module rv64ie_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire rv64ie_pkg::t_cmd   i_cmd,
    output logic                    o_ready,
    output logic                    o_valid,
    output rv64ie_pkg::t_out_item   o_item,
    input  wire                     i_stall
);

    localparam int DivSteps = 64;

    typedef struct packed {
        rv64ie_pkg::t_kind kind;
        logic        word;
        logic [2:0]  funct3;
        logic [4:0]  dest_index;
        logic [31:0] instruction_word;
        logic [63:0] value;
        logic        neg_q;
        logic        neg_r;
        logic        zero;
        logic        ovf;
        logic [63:0] dividend;
    } t_meta;

    // Stage bookkeeping for the divide pipeline and the multiply partials.
    logic            r_v   [DivSteps+1];
    t_meta           r_m   [DivSteps+1];
    logic [63:0]     r_q   [DivSteps+1];
    logic [63:0]     r_r   [DivSteps+1];
    logic [63:0]     r_d   [DivSteps+1];
    logic [63:0]     r_p0  [DivSteps+1];
    logic [63:0]     r_p1  [DivSteps+1];
    logic [63:0]     r_p2  [DivSteps+1];
    logic [63:0]     r_p3  [DivSteps+1];

    logic            w_adv;
    logic            r_ov;
    rv64ie_pkg::t_out_item r_out;

    assign w_adv   = !r_ov || !i_stall;
    assign o_ready = w_adv;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    function automatic logic [63:0] sext32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    // Stage 0: ALU result, divider setup and multiply partial products.
    t_meta       w_m0;
    logic [63:0] w_a, w_b, w_sum, w_alu, w_ua, w_ub, w_sh, w_src;
    logic [63:0] w_ma, w_mb;
    logic        w_sa, w_sb, w_na, w_nb;

    always_comb begin
        w_a = i_cmd.opa;
        w_b = i_cmd.opb;
        w_sum = i_cmd.alt ? (w_a - w_b) : (w_a + w_b);
        w_src = i_cmd.word ? (i_cmd.alt ? sext32(w_a) : {32'd0, w_a[31:0]}) : w_a;
        if (i_cmd.alt) begin
            w_sh = $signed(w_src) >>> i_cmd.shamt;
        end else begin
            w_sh = w_src >> i_cmd.shamt;
        end
        case (i_cmd.funct3)
            rv64ie_pkg::F3_ADD:  w_alu = i_cmd.pass_b ? w_b : w_sum;
            rv64ie_pkg::F3_SLL:  w_alu = w_a << i_cmd.shamt;
            rv64ie_pkg::F3_SLT:  w_alu = {63'd0, $signed(w_a) < $signed(w_b)};
            rv64ie_pkg::F3_SLTU: w_alu = {63'd0, w_a < w_b};
            rv64ie_pkg::F3_XOR:  w_alu = w_a ^ w_b;
            rv64ie_pkg::F3_SRL:  w_alu = w_sh;
            rv64ie_pkg::F3_OR:   w_alu = w_a | w_b;
            default:             w_alu = w_a & w_b;
        endcase
        if (i_cmd.word) begin
            w_alu = sext32(w_alu);
        end

        w_sa = (i_cmd.funct3 == rv64ie_pkg::F3_MULH) || (i_cmd.funct3 == rv64ie_pkg::F3_MULHSU);
        w_sb = (i_cmd.funct3 == rv64ie_pkg::F3_MULH);
        w_ma = w_a;
        w_mb = w_b;

        // Divide operands, 32-bit forms work on the sign- or zero-extended low word.
        if (i_cmd.word) begin
            w_ua = i_cmd.funct3[0] ? {32'd0, w_a[31:0]} : sext32(w_a);
            w_ub = i_cmd.funct3[0] ? {32'd0, w_b[31:0]} : sext32(w_b);
        end else begin
            w_ua = w_a;
            w_ub = w_b;
        end
        w_na = !i_cmd.funct3[0] && w_ua[63];
        w_nb = !i_cmd.funct3[0] && w_ub[63];

        w_m0 = '0;
        w_m0.kind             = i_cmd.kind;
        w_m0.word             = i_cmd.word;
        w_m0.funct3           = i_cmd.funct3;
        w_m0.dest_index       = i_cmd.dest_index;
        w_m0.instruction_word = i_cmd.instruction_word;
        w_m0.value            = w_alu;
        w_m0.neg_q            = w_na ^ w_nb;
        w_m0.neg_r            = w_na;
        w_m0.zero             = (w_ub == 64'd0);
        w_m0.ovf              = w_na && w_nb && (w_ub == '1) &&
                                (w_ua == {1'b1, 63'd0} ||
                                 (i_cmd.word && w_ua == {{33{1'b1}}, 31'd0}));
        w_m0.dividend         = w_ua;
        if (i_cmd.kind == rv64ie_pkg::K_MUL) begin
            w_m0.value = (w_sa && w_a[63]) ? w_b : 64'd0;
            w_m0.neg_r = w_sb && w_b[63];
        end
    end

    // Multiply: 32x32 partials registered at stage 0, summed at the final stage.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m[0]  <= w_m0;
            r_r[0]  <= '0;
            // Multiply items carry the first operand here for the high-word sign fix.
            if (i_cmd.kind == rv64ie_pkg::K_MUL) begin
                r_d[0] <= w_a;
            end else begin
                r_d[0] <= w_nb ? (64'd0 - w_ub) : w_ub;
            end
            r_p0[0] <= {32'd0, w_ma[31:0]} * {32'd0, w_mb[31:0]};
            r_p1[0] <= {32'd0, w_ma[31:0]} * {32'd0, w_mb[63:32]};
            r_p2[0] <= {32'd0, w_ma[63:32]} * {32'd0, w_mb[31:0]};
            r_p3[0] <= {32'd0, w_ma[63:32]} * {32'd0, w_mb[63:32]};
            // The magnitude of the dividend rides in r_q and shifts out as quotient bits.
            r_q[0]  <= w_na ? (64'd0 - w_ua) : w_ua;
        end
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        logic [64:0] w_rem;
        logic [64:0] w_try;
        always_comb begin
            w_rem = {r_r[g], r_q[g][63]};
            w_try = w_rem - {1'b0, r_d[g]};
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_m[g+1]  <= r_m[g];
                r_d[g+1]  <= r_d[g];
                r_p0[g+1] <= r_p0[g];
                r_p1[g+1] <= r_p1[g];
                r_p2[g+1] <= r_p2[g];
                r_p3[g+1] <= r_p3[g];
                if (!w_try[64]) begin
                    r_r[g+1] <= w_try[63:0];
                    r_q[g+1] <= {r_q[g][62:0], 1'b1};
                end else begin
                    r_r[g+1] <= w_rem[63:0];
                    r_q[g+1] <= {r_q[g][62:0], 1'b0};
                end
            end
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_v[g+1] <= r_v[g];
            end
        end
    end

    // Final stage: combine products, fix up division signs, form the item.
    t_meta       w_mf;
    logic [63:0] w_mid, w_lo, w_hi, w_q, w_r, w_res;
    rv64ie_pkg::t_out_item w_out;

    always_comb begin
        w_mf  = r_m[DivSteps];
        w_mid = {32'd0, r_p0[DivSteps][63:32]} + {32'd0, r_p1[DivSteps][31:0]} +
                {32'd0, r_p2[DivSteps][31:0]};
        w_lo  = {w_mid[31:0], r_p0[DivSteps][31:0]};
        w_hi  = r_p3[DivSteps] + {32'd0, r_p1[DivSteps][63:32]} +
                {32'd0, r_p2[DivSteps][63:32]} + {32'd0, w_mid[63:32]};
        w_q   = w_mf.neg_q ? (64'd0 - r_q[DivSteps]) : r_q[DivSteps];
        w_r   = w_mf.neg_r ? (64'd0 - r_r[DivSteps]) : r_r[DivSteps];
        case (w_mf.kind)
            rv64ie_pkg::K_MUL: begin
                case (w_mf.funct3)
                    rv64ie_pkg::F3_MUL:    w_res = w_lo;
                    rv64ie_pkg::F3_MULH:   w_res = w_hi - w_mf.value -
                                                   (w_mf.neg_r ? r_d[DivSteps] : 64'd0);
                    rv64ie_pkg::F3_MULHSU: w_res = w_hi - w_mf.value;
                    default:               w_res = w_hi;
                endcase
                if (w_mf.word) begin
                    w_res = sext32(w_lo);
                end
            end
            rv64ie_pkg::K_DIV: begin
                if (w_mf.zero) begin
                    w_res = w_mf.funct3[1] ? w_mf.dividend : '1;
                end else if (w_mf.ovf) begin
                    w_res = w_mf.funct3[1] ? 64'd0 : w_mf.dividend;
                end else begin
                    w_res = w_mf.funct3[1] ? w_r : w_q;
                end
                if (w_mf.word) begin
                    w_res = sext32(w_res);
                end
            end
            default: w_res = w_mf.value;
        endcase
        w_out = '0;
        case (w_mf.kind)
            rv64ie_pkg::K_ILLEGAL: begin
                w_out.illegal    = 1'b1;
                w_out.trap_value = w_mf.instruction_word;
            end
            rv64ie_pkg::K_FENCE: begin
                w_out.retired = 1'b1;
            end
            default: begin
                w_out.retired      = 1'b1;
                w_out.write_enable = 1'b1;
                w_out.write_index  = w_mf.dest_index;
                w_out.write_value  = w_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_out;
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_v[DivSteps];
        end
    end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for rv64im_integer_execute: random and directed RV64IM items with
// an in-bench predictor and an in-order scoreboard. Depends on rv64ie_pkg.
`default_nettype none
module tb_top;

    localparam int MAX_CYCLES = 400000;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    class result_board;
        rv64ie_pkg::t_out_item pending[$];
        int errors;
        int shown;

        function void note_item(rv64ie_pkg::t_out_item exp_item);
            pending.push_back(exp_item);
        endfunction

        function void check_result(rv64ie_pkg::t_out_item got);
            rv64ie_pkg::t_out_item exp_item;
            if (pending.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result %h", got);
                end
                return;
            end
            exp_item = pending.pop_front();
            if (got !== exp_item) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch: expected we=%0b idx=%0d val=%h ill=%0b tv=%h ret=%0b",
                        exp_item.write_enable, exp_item.write_index, exp_item.write_value,
                        exp_item.illegal, exp_item.trap_value, exp_item.retired);
                    $display("          actual   we=%0b idx=%0d val=%h ill=%0b tv=%h ret=%0b",
                        got.write_enable, got.write_index, got.write_value,
                        got.illegal, got.trap_value, got.retired);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    rv64ie_pkg::t_in_item i_item = '0;
    logic o_stall;
    logic o_valid;
    rv64ie_pkg::t_out_item o_item;

    result_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    rv64im_integer_execute u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] sext32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] sdiv_q(input logic [63:0] a, input logic [63:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        sa = a;
        sb = b;
        if (a == SIGN64 && b == '1) return a;
        return sa / sb;
    endfunction

    function automatic logic [63:0] sdiv_r(input logic [63:0] a, input logic [63:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        sa = a;
        sb = b;
        if (a == SIGN64 && b == '1) return '0;
        return sa % sb;
    endfunction

    function automatic rv64ie_pkg::t_out_item execute_result(input rv64ie_pkg::t_in_item it);
        rv64ie_pkg::t_out_item r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] imm;
        logic [63:0] v;
        logic [127:0] p;
        logic [5:0] s;
        logic alt;
        logic wr;
        logic bad;
        a = it.src1_value;
        b = it.src2_value;
        imm = it.immediate;
        alt = it.funct7[5];
        wr = 1'b1;
        bad = 1'b0;
        v = '0;
        case (it.op)
            rv64ie_pkg::OP_LUI: v = imm;
            rv64ie_pkg::OP_AUIPC: v = it.insn_address + imm;
            rv64ie_pkg::OP_IMM: begin
                s = {it.funct7[0], it.shift_field};
                case (it.funct3)
                    rv64ie_pkg::F3_ADD: v = a + imm;
                    rv64ie_pkg::F3_SLL: v = a << s;
                    rv64ie_pkg::F3_SLT: v = ($signed(a) < $signed(imm)) ? 64'd1 : 64'd0;
                    rv64ie_pkg::F3_SLTU: v = (a < imm) ? 64'd1 : 64'd0;
                    rv64ie_pkg::F3_XOR: v = a ^ imm;
                    rv64ie_pkg::F3_SRL: begin
                        if (alt) v = $signed(a) >>> s;
                        else v = a >> s;
                    end
                    rv64ie_pkg::F3_OR: v = a | imm;
                    default: v = a & imm;
                endcase
            end
            rv64ie_pkg::OP_IMM32: begin
                case (it.funct3)
                    rv64ie_pkg::F3_ADD: v = sext32(a + imm);
                    rv64ie_pkg::F3_SLL: v = sext32({32'd0, a[31:0]} << it.shift_field);
                    rv64ie_pkg::F3_SRL: v = alt ? sext32($signed(sext32(a)) >>> it.shift_field)
                                                : sext32({32'd0, a[31:0]} >> it.shift_field);
                    default: bad = 1'b1;
                endcase
            end
            rv64ie_pkg::OP_REG: begin
                if (it.funct7 == rv64ie_pkg::F7_MULDIV) begin
                    case (it.funct3)
                        rv64ie_pkg::F3_MUL: v = a * b;
                        rv64ie_pkg::F3_MULH: begin
                            p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                            v = p[127:64];
                        end
                        rv64ie_pkg::F3_MULHSU: begin
                            p = {{64{a[63]}}, a} * {64'd0, b};
                            v = p[127:64];
                        end
                        rv64ie_pkg::F3_MULHU: begin
                            p = {64'd0, a} * {64'd0, b};
                            v = p[127:64];
                        end
                        rv64ie_pkg::F3_DIV: v = (b != 0) ? sdiv_q(a, b) : '1;
                        rv64ie_pkg::F3_DIVU: v = (b != 0) ? a / b : '1;
                        rv64ie_pkg::F3_REM: v = (b != 0) ? sdiv_r(a, b) : a;
                        default: v = (b != 0) ? a % b : a;
                    endcase
                end else begin
                    s = b[5:0];
                    case (it.funct3)
                        rv64ie_pkg::F3_ADD: v = alt ? a - b : a + b;
                        rv64ie_pkg::F3_SLL: v = a << s;
                        rv64ie_pkg::F3_SLT: v = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                        rv64ie_pkg::F3_SLTU: v = (a < b) ? 64'd1 : 64'd0;
                        rv64ie_pkg::F3_XOR: v = a ^ b;
                        rv64ie_pkg::F3_SRL: begin
                            if (alt) v = $signed(a) >>> s;
                            else v = a >> s;
                        end
                        rv64ie_pkg::F3_OR: v = a | b;
                        default: v = a & b;
                    endcase
                end
            end
            rv64ie_pkg::OP_REG32: begin
                if (it.funct7 == rv64ie_pkg::F7_MULDIV) begin
                    case (it.funct3)
                        rv64ie_pkg::F3_MUL: v = sext32(a * b);
                        rv64ie_pkg::F3_DIV: v = (b[31:0] != 0)
                            ? sext32(sdiv_q(sext32(a), sext32(b))) : '1;
                        rv64ie_pkg::F3_DIVU: v = (b[31:0] != 0)
                            ? sext32({32'd0, a[31:0] / b[31:0]}) : '1;
                        rv64ie_pkg::F3_REM: v = (b[31:0] != 0)
                            ? sext32(sdiv_r(sext32(a), sext32(b))) : sext32(a);
                        rv64ie_pkg::F3_REMU: v = (b[31:0] != 0)
                            ? sext32({32'd0, a[31:0] % b[31:0]}) : sext32(a);
                        default: bad = 1'b1;
                    endcase
                end else begin
                    case (it.funct3)
                        rv64ie_pkg::F3_ADD: v = sext32(alt ? a - b : a + b);
                        rv64ie_pkg::F3_SLL: v = sext32({32'd0, a[31:0]} << b[4:0]);
                        rv64ie_pkg::F3_SRL: v = alt ? sext32($signed(sext32(a)) >>> b[4:0])
                                                    : sext32({32'd0, a[31:0]} >> b[4:0]);
                        default: bad = 1'b1;
                    endcase
                end
            end
            rv64ie_pkg::OP_FENCE: wr = 1'b0;
            default: bad = 1'b1;
        endcase
        r = '0;
        if (bad) begin
            r.illegal = 1'b1;
            r.trap_value = it.instruction_word;
        end else begin
            r.write_enable = wr;
            r.write_index = wr ? it.dest_index : 5'd0;
            r.write_value = wr ? v : 64'd0;
            r.retired = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return SIGN64;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return sext32({32'd0, $urandom()});
            5: return {32'd0, $urandom()};
            6: return 64'($urandom_range(0, 70));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic rv64ie_pkg::t_in_item rand_item();
        rv64ie_pkg::t_in_item it;
        logic [6:0] ops[7];
        ops = '{rv64ie_pkg::OP_LUI, rv64ie_pkg::OP_AUIPC, rv64ie_pkg::OP_IMM,
                rv64ie_pkg::OP_IMM32, rv64ie_pkg::OP_REG, rv64ie_pkg::OP_REG32,
                rv64ie_pkg::OP_FENCE};
        it.op = ($urandom_range(0, 19) == 0) ? 7'($urandom()) : ops[$urandom_range(0, 6)];
        it.funct3 = 3'($urandom());
        case ($urandom_range(0, 3))
            0: it.funct7 = rv64ie_pkg::F7_MULDIV;
            1: it.funct7 = 7'h20;
            2: it.funct7 = 7'h00;
            default: it.funct7 = 7'($urandom());
        endcase
        it.shift_field = 5'($urandom());
        it.dest_index = 5'($urandom());
        it.instruction_word = $urandom();
        it.src1_value = rand_operand();
        it.src2_value = rand_operand();
        it.immediate = rand_operand();
        it.insn_address = {$urandom(), $urandom()};
        return it;
    endfunction

    task automatic send_item(input rv64ie_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_item(execute_result(it));
    endtask

    task automatic send_directed();
        rv64ie_pkg::t_in_item it;
        logic [2:0] f3;
        for (int k = 0; k < 24; k++) begin
            it = rand_item();
            f3 = 3'(k % 8);
            it.funct3 = f3;
            case (k / 8)
                0: begin
                    it.op = rv64ie_pkg::OP_REG;
                    it.funct7 = rv64ie_pkg::F7_MULDIV;
                    it.src1_value = SIGN64;
                    it.src2_value = (k % 2) ? '1 : 64'd0;
                end
                1: begin
                    it.op = rv64ie_pkg::OP_REG32;
                    it.funct7 = rv64ie_pkg::F7_MULDIV;
                    it.src1_value = 64'hFFFF_FFFF_8000_0000;
                    it.src2_value = (k % 2) ? '1 : 64'hABCD_0000_0000_0000;
                end
                default: begin
                    it.op = (k % 2) ? rv64ie_pkg::OP_IMM : rv64ie_pkg::OP_REG;
                    it.funct7 = 7'h21;
                    it.shift_field = '1;
                    it.dest_index = 5'd0;
                    it.src1_value = '1;
                    it.src2_value = '1;
                    it.immediate = SIGN64;
                end
            endcase
            send_item(it);
        end
        it = rand_item();
        it.op = 7'h7F;
        it.instruction_word = '1;
        send_item(it);
        it.op = rv64ie_pkg::OP_FENCE;
        send_item(it);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_item);
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        if (cycle_count > MAX_CYCLES) begin
            $display("FAIL rv64im_integer_execute");
            $finish;
        end
    end

    initial begin
        int idle_pct[4];
        int stall_pct[4];
        idle_pct = '{0, 71, 0, 23};
        stall_pct = '{0, 0, 71, 23};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = idle_pct[ph % 4];
            recv_stall_pct = stall_pct[ph % 4];
            for (int n = 0; n < 160; n++) send_item(rand_item());
        end
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS rv64im_integer_execute");
        end else begin
            $display("FAIL rv64im_integer_execute");
        end
        $finish;
    end
endmodule
`default_nettype wire
